### rtl/osa_pkg.sv
// Shared types and constants for the obstacle scan-and-avoid controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package osa_pkg;

  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    REG_TRIGGER_CM   = 3'd0,
    REG_TURN_RATE    = 3'd1,
    REG_SCAN_RANGE   = 3'd2,
    REG_SCAN_CAP     = 3'd3,
    REG_SETTLE_TICKS = 3'd4,
    REG_TURN_TIMEOUT = 3'd5,
    REG_TOLERANCE    = 3'd6,
    REG_CONFIRM      = 3'd7
  } reg_idx_t;

  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_IDLE  = 3'd1;
  localparam logic [2:0] MODE_BRAKE = 3'd2;
  localparam logic [2:0] MODE_SCAN1 = 3'd3;
  localparam logic [2:0] MODE_SCAN2 = 3'd4;
  localparam logic [2:0] MODE_TURN  = 3'd5;
  localparam logic [2:0] MODE_DONE  = 3'd6;

  typedef enum logic [6:0] {
    ST_OFF   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_BRAKE = 7'b0000100,
    ST_SCAN1 = 7'b0001000,
    ST_SCAN2 = 7'b0010000,
    ST_TURN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [11:0] trigger_cm;
    logic [6:0]  turn_rate;
    logic [14:0] scan_range_cdeg;
    logic [14:0] scan_cap;
    logic [15:0] settle_ticks;
    logic [15:0] turn_timeout;
    logic [14:0] tolerance_cdeg;
    logic [7:0]  confirm_count;
  } cfg_t;

  typedef struct packed {
    logic        enable;
    logic [11:0] distance_cm;
    logic [15:0] yaw_cdeg;
  } item_t;

  typedef struct packed {
    logic       drive_write;
    logic [7:0] yaw_rate_cmd;
    logic [2:0] mode;
    logic       maneuver_active;
  } result_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic       in_band;
  } steer_t;

  localparam logic signed [17:0] WRAP_POS  = 18'sd18000;
  localparam logic signed [17:0] WRAP_NEG  = -18'sd18000;
  localparam logic signed [17:0] WRAP_FULL = 18'sd36000;

  // single wrap step, may leave values beyond half a turn
  function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
    if (a > WRAP_POS) begin
      return a - WRAP_FULL;
    end else if (a < WRAP_NEG) begin
      return a + WRAP_FULL;
    end else begin
      return a;
    end
  endfunction

  function automatic logic [2:0] mode_of(input state_t s);
    logic [2:0] m;
    unique case (s)
      ST_OFF:   m = MODE_OFF;
      ST_IDLE:  m = MODE_IDLE;
      ST_BRAKE: m = MODE_BRAKE;
      ST_SCAN1: m = MODE_SCAN1;
      ST_SCAN2: m = MODE_SCAN2;
      ST_TURN:  m = MODE_TURN;
      ST_DONE:  m = MODE_DONE;
      default:  m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/osa_cfg_regs.sv
// Configuration register file of the scan-and-avoid controller.
// Depends on osa_pkg (cfg_t, reg_idx_t).
`default_nettype none

module osa_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  osa_pkg::reg_idx_t                    wr_index,
  input  logic [osa_pkg::CFG_DATA_W-1:0]       wr_data,
  output osa_pkg::cfg_t                        cfg
);
  import osa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_cm      <= 12'd25;
      cfg.turn_rate       <= 7'd50;
      cfg.scan_range_cdeg <= 15'd6000;
      cfg.scan_cap        <= 15'd120;
      cfg.settle_ticks    <= 16'd15;
      cfg.turn_timeout    <= 16'd150;
      cfg.tolerance_cdeg  <= 15'd800;
      cfg.confirm_count   <= 8'd5;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRIGGER_CM:   cfg.trigger_cm      <= wr_data[11:0];
        REG_TURN_RATE:    cfg.turn_rate       <= wr_data[6:0];
        REG_SCAN_RANGE:   cfg.scan_range_cdeg <= wr_data[14:0];
        REG_SCAN_CAP:     cfg.scan_cap        <= wr_data[14:0];
        REG_SETTLE_TICKS: cfg.settle_ticks    <= wr_data[15:0];
        REG_TURN_TIMEOUT: cfg.turn_timeout    <= wr_data[15:0];
        REG_TOLERANCE:    cfg.tolerance_cdeg  <= wr_data[14:0];
        REG_CONFIRM:      cfg.confirm_count   <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/osa_steer.sv
// Proportional steering of the turn phase: heading error, divide by 50, clamp.
// Depends on osa_pkg (wrap_once, steer_t).
`default_nettype none

module osa_steer (
  input  logic signed [15:0] best_heading,
  input  logic signed [15:0] rel,
  input  logic               turn_neg,
  input  logic [6:0]         turn_rate,
  input  logic [14:0]        tolerance_cdeg,
  output osa_pkg::steer_t    steer
);
  import osa_pkg::*;

  // |x|/50 for |x| < 128*50 by x*5243 >> 18; above that the clamp wins anyway
  localparam logic [15:0] DIV_SPAN  = 16'd6400;
  localparam logic [12:0] RECIP_50  = 13'd5243;

  logic signed [17:0] err_w;
  logic signed [15:0] err;
  logic signed [16:0] serr;
  logic [15:0]        mag;
  logic [25:0]        prod;
  logic [7:0]         quo;
  logic               sat;
  logic [6:0]         mag_cl;
  logic signed [15:0] tol_s;

  always_comb begin
    err_w  = wrap_once(18'(best_heading) - 18'(rel));
    err    = err_w[15:0];
    serr   = turn_neg ? -17'(err) : 17'(err);
    mag    = serr[16] ? 16'(-serr) : serr[15:0];
    sat    = (mag >= DIV_SPAN);
    prod   = 26'(mag[12:0]) * 26'(RECIP_50);
    quo    = prod[25:18];
    mag_cl = (sat || (quo > {1'b0, turn_rate})) ? turn_rate : quo[6:0];
    steer.cmd = serr[16] ? 8'(-$signed({1'b0, mag_cl})) : {1'b0, mag_cl};
    tol_s  = $signed({1'b0, tolerance_cdeg});
    steer.in_band = (err < tol_s) && (err > -tol_s);
  end

endmodule

`default_nettype wire

### rtl/osa_fsm.sv
// Mode sequencer with sweep, best-heading tracking and tick counters.
// Depends on osa_pkg and osa_steer; one step per accepted request.
`default_nettype none

module osa_fsm #(
  parameter int FAR_CLEARANCE = 400
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  osa_pkg::item_t    item,
  input  osa_pkg::cfg_t     cfg,
  output osa_pkg::result_t  res
);
  import osa_pkg::*;

  localparam logic [11:0] FAR_CM = 12'(FAR_CLEARANCE);

  state_t             state, state_next;
  logic               armed, armed_next;
  logic [15:0]        tick_timer, tick_timer_next;
  logic [7:0]         confirm_counter, confirm_counter_next;
  logic signed [15:0] entry_heading, entry_heading_next;
  logic signed [15:0] best_heading, best_heading_next;
  logic [11:0]        best_clearance, best_clearance_next;
  logic               turn_neg, turn_neg_next;

  logic signed [17:0] rel_w;
  logic signed [15:0] rel;
  logic signed [15:0] yaw;
  logic signed [15:0] range_s;
  logic signed [7:0]  rate_s;
  logic [11:0]        clr;
  logic [15:0]        tick_inc;
  logic [7:0]         conf_inc;
  logic               near;
  logic               dw;
  logic [7:0]         cmd;
  steer_t             steer;

  assign yaw      = item.yaw_cdeg;
  assign rel_w    = wrap_once(18'(yaw) - 18'(entry_heading));
  assign rel      = rel_w[15:0];
  assign range_s  = $signed({1'b0, cfg.scan_range_cdeg});
  assign rate_s   = $signed({1'b0, cfg.turn_rate});
  assign clr      = (item.distance_cm == '0) ? FAR_CM : item.distance_cm;
  assign tick_inc = tick_timer + 16'd1;
  assign near     = (item.distance_cm != '0) && (item.distance_cm < cfg.trigger_cm);

  osa_steer u_steer (
    .best_heading   (best_heading),
    .rel            (rel),
    .turn_neg       (turn_neg),
    .turn_rate      (cfg.turn_rate),
    .tolerance_cdeg (cfg.tolerance_cdeg),
    .steer          (steer)
  );

  assign conf_inc = steer.in_band ? confirm_counter + 8'd1 : 8'd0;

  always_comb begin
    state_next           = state;
    armed_next           = armed;
    tick_timer_next      = tick_timer;
    confirm_counter_next = confirm_counter;
    entry_heading_next   = entry_heading;
    best_heading_next    = best_heading;
    best_clearance_next  = best_clearance;
    turn_neg_next        = turn_neg;
    dw                   = 1'b0;
    cmd                  = 8'd0;

    if (!item.enable) begin
      state_next = ST_OFF;
    end else if (state == ST_OFF) begin
      state_next = ST_IDLE;
      armed_next = 1'b1;
    end

    if (item.enable) begin
      unique case (state_next)
        ST_OFF: ;
        ST_IDLE: begin
          if (!near) armed_next = 1'b1;
          if (armed_next && near) begin
            dw                  = 1'b1;
            entry_heading_next  = yaw;
            best_heading_next   = '0;
            best_clearance_next = '0;
            armed_next          = 1'b0;
            tick_timer_next     = '0;
            state_next          = ST_BRAKE;
          end
        end
        ST_BRAKE: begin
          dw              = 1'b1;
          tick_timer_next = tick_inc;
          if (tick_inc >= cfg.settle_ticks) begin
            tick_timer_next = '0;
            state_next      = ST_SCAN1;
          end
        end
        ST_SCAN1: begin
          dw  = 1'b1;
          cmd = rate_s;
          if (clr > best_clearance) begin
            best_clearance_next = clr;
            best_heading_next   = rel;
          end
          if ((rel >= range_s) || (rel <= -range_s)) begin
            turn_neg_next   = rel[15];
            tick_timer_next = '0;
            state_next      = ST_SCAN2;
          end else begin
            tick_timer_next = tick_inc;
            if (tick_inc >= 16'(cfg.scan_cap)) begin
              turn_neg_next   = rel[15];
              tick_timer_next = '0;
              state_next      = ST_SCAN2;
            end
          end
        end
        ST_SCAN2: begin
          dw  = 1'b1;
          cmd = 8'(-rate_s);
          if (clr > best_clearance) begin
            best_clearance_next = clr;
            best_heading_next   = rel;
          end
          tick_timer_next = tick_inc;
          if ((turn_neg ? (rel >= range_s) : (rel <= -range_s)) ||
              (tick_inc >= {cfg.scan_cap, 1'b0})) begin
            cmd                  = 8'd0;
            tick_timer_next      = '0;
            confirm_counter_next = '0;
            state_next           = ST_TURN;
          end
        end
        ST_TURN: begin
          dw                   = 1'b1;
          cmd                  = steer.cmd;
          confirm_counter_next = conf_inc;
          if (conf_inc >= cfg.confirm_count) begin
            cmd                  = 8'd0;
            tick_timer_next      = '0;
            confirm_counter_next = '0;
            state_next           = ST_DONE;
          end else begin
            tick_timer_next = tick_inc;
            if (tick_inc >= cfg.turn_timeout) begin
              cmd                  = 8'd0;
              tick_timer_next      = '0;
              confirm_counter_next = '0;
              state_next           = ST_DONE;
            end
          end
        end
        ST_DONE: begin
          dw              = 1'b1;
          tick_timer_next = tick_inc;
          if (tick_inc >= cfg.settle_ticks) begin
            tick_timer_next = '0;
            state_next      = ST_IDLE;
          end
        end
        default: state_next = ST_IDLE;
      endcase
    end

    res.drive_write     = dw;
    res.yaw_rate_cmd    = cmd;
    res.mode            = mode_of(state_next);
    res.maneuver_active = (state_next != ST_OFF) && (state_next != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_OFF;
      armed           <= 1'b1;
      tick_timer      <= '0;
      confirm_counter <= '0;
      entry_heading   <= '0;
      best_heading    <= '0;
      best_clearance  <= '0;
      turn_neg        <= 1'b0;
    end else if (step_en) begin
      state           <= state_next;
      armed           <= armed_next;
      tick_timer      <= tick_timer_next;
      confirm_counter <= confirm_counter_next;
      entry_heading   <= entry_heading_next;
      best_heading    <= best_heading_next;
      best_clearance  <= best_clearance_next;
      turn_neg        <= turn_neg_next;
    end
  end

endmodule

`default_nettype wire

### rtl/obstacle_scan_avoid_fsm_top.sv
// Top level of the obstacle scan-and-avoid controller: request and result registers.
// Depends on osa_pkg, osa_cfg_regs, osa_fsm (which holds osa_steer).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_stall  | enable, distance_cm, yaw_cdeg
//   out      | out_valid / out_stall| drive_write, yaw_rate_cmd, mode, maneuver_active
//   config   | wr_en                | wr_index, wr_data
//
// One request per cycle sustained while the result is not stalled; a request passes the request
// register, then the sequencer's step into the result register.
// Synchronous reset: mode off, armed, counters and headings cleared, config defaults.
// A stalled result holds the request register; in_stall rises only while both are full.
`default_nettype none

module obstacle_scan_avoid_fsm_top #(
  parameter int FAR_CLEARANCE = 400
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            enable,
  input  logic [11:0]                     distance_cm,
  input  logic signed [15:0]              yaw_cdeg,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            drive_write,
  output logic signed [7:0]               yaw_rate_cmd,
  output logic [2:0]                      mode,
  output logic                            maneuver_active,
  input  logic                            wr_en,
  input  osa_pkg::reg_idx_t               wr_index,
  input  logic [osa_pkg::CFG_DATA_W-1:0]  wr_data
);
  import osa_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t res;
  result_t out_res;
  logic    advance;
  logic    in_take;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  osa_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  osa_fsm #(
    .FAR_CLEARANCE (FAR_CLEARANCE)
  ) u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.enable      <= enable;
      s1_item.distance_cm <= distance_cm;
      s1_item.yaw_cdeg    <= yaw_cdeg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign drive_write     = out_res.drive_write;
  assign yaw_rate_cmd    = out_res.yaw_rate_cmd;
  assign mode            = out_res.mode;
  assign maneuver_active = out_res.maneuver_active;

  a_stall_needs_request: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held request");

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> (s1_valid && $stable(s1_item)))
    else $error("held request lost under output stall");

  a_no_drive_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drive_write) |-> (yaw_rate_cmd == 8'sd0))
    else $error("yaw command without drive write");

  a_cmd_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((yaw_rate_cmd <= $signed({1'b0, cfg.turn_rate})) &&
                   (yaw_rate_cmd >= -$signed({1'b0, cfg.turn_rate}))))
    else $error("yaw command beyond turn rate");

  a_off_is_passive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mode == MODE_OFF)) |-> (!drive_write && !maneuver_active))
    else $error("drive activity while off");

endmodule

`default_nettype wire

### tb/sv/obstacle_scan_avoid_fsm_top_tb.sv
// Testbench for obstacle_scan_avoid_fsm_top: a directed table, then tuning phases of random
// ticks from a simple heading plant, checked against an in-bench predictor or pinned results.
// Depends on osa_pkg and the block's RTL only.
`timescale 1ns / 100ps

module obstacle_scan_avoid_fsm_top_tb;
  import osa_pkg::*;

  localparam int FAR_ECHO_CM = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 28;

  localparam result_t R_NONE  = '0;
  localparam result_t R_OFF   = '{1'b0, 8'd0, MODE_OFF, 1'b0};
  localparam result_t R_IDLE  = '{1'b0, 8'd0, MODE_IDLE, 1'b0};
  localparam result_t R_BRAKE = '{1'b1, 8'd0, MODE_BRAKE, 1'b1};

  localparam cfg_t DIRECTED_TUNING = '{12'd25, 7'd50, 15'd6000, 15'd3, 16'd2, 16'd4,
                                       15'd800, 8'd2};

  typedef struct {
    logic        en;
    logic [11:0] dist_cm;
    int          yaw;
    bit          pinned;
    result_t     want;
  } probe_t;

  probe_t probes [26] = '{
    '{1'b0, 12'd0,    0,      1'b1, R_OFF},
    '{1'b1, 12'd4095, 18000,  1'b1, R_IDLE},
    '{1'b1, 12'd0,    -18000, 1'b1, R_IDLE},
    '{1'b1, 12'd24,   1000,   1'b1, R_BRAKE},
    '{1'b1, 12'd24,   1000,   1'b0, R_NONE},
    '{1'b1, 12'd3000, 1000,   1'b0, R_NONE},
    '{1'b1, 12'd0,    8000,   1'b0, R_NONE},
    '{1'b1, 12'd4095, -17000, 1'b0, R_NONE},
    '{1'b1, 12'd100,  17000,  1'b0, R_NONE},
    '{1'b1, 12'd100,  17500,  1'b0, R_NONE},
    '{1'b1, 12'd100,  -18000, 1'b0, R_NONE},
    '{1'b1, 12'd100,  -17000, 1'b0, R_NONE},
    '{1'b1, 12'd100,  0,      1'b0, R_NONE},
    '{1'b1, 12'd100,  0,      1'b0, R_NONE},
    '{1'b1, 12'd5,    0,      1'b1, R_IDLE},
    '{1'b1, 12'd30,   0,      1'b1, R_IDLE},
    '{1'b1, 12'd1,    -18000, 1'b1, R_BRAKE},
    '{1'b0, 12'd1,    -18000, 1'b1, R_OFF},
    '{1'b1, 12'd1,    0,      1'b1, R_BRAKE},
    '{1'b1, 12'd4095, 0,      1'b0, R_NONE},
    '{1'b1, 12'd200,  0,      1'b0, R_NONE},
    '{1'b1, 12'd4095, -7000,  1'b0, R_NONE},
    '{1'b1, 12'd300,  5000,   1'b0, R_NONE},
    '{1'b1, 12'd300,  7000,   1'b0, R_NONE},
    '{1'b1, 12'd300,  -6900,  1'b0, R_NONE},
    '{1'b1, 12'd300,  -7000,  1'b0, R_NONE}
  };

  cfg_t phase_tunings [7] = '{
    '{12'd25,   7'd50,  15'd6000,  15'd120,   16'd15,    16'd150,   15'd800,   8'd5},
    '{12'd4095, 7'd0,   15'd1,     15'd1,     16'd1,     16'd1,     15'd0,     8'd1},
    '{12'd2000, 7'd127, 15'd18000, 15'd32767, 16'd3,     16'd65535, 15'd18000, 8'd255},
    '{12'd4095, 7'd50,  15'd6000,  15'd120,   16'd65535, 16'd150,   15'd800,   8'd5},
    '{12'd300,  7'd0,   15'd0,     15'd0,     16'd0,     16'd0,     15'd0,     8'd0},
    '{12'd700,  7'd90,  15'd3000,  15'd20,    16'd4,     16'd40,    15'd500,   8'd8},
    '{12'd25,   7'd50,  15'd6000,  15'd120,   16'd15,    16'd150,   15'd800,   8'd5}
  };
  int phase_items [7] = '{260, 200, 300, 40, 150, 300, 250};

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              enable = 1'b0;
  logic [11:0]       distance_cm = '0;
  logic signed [15:0] yaw_cdeg = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              drive_write;
  logic signed [7:0] yaw_rate_cmd;
  logic [2:0]        mode;
  logic              maneuver_active;
  logic              wr_en = 1'b0;
  reg_idx_t          wr_index = REG_TRIGGER_CM;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  // predictor state and tuning
  cfg_t        tuning;
  logic [2:0]  nav_mode = MODE_OFF;
  logic [15:0] nav_timer = '0;
  logic [7:0]  nav_confirm = '0;
  logic        nav_armed = 1'b1;
  int          nav_entry = 0;
  int          nav_best_hdg = 0;
  int          nav_best_clr = 0;
  int          nav_sign = 1;

  result_t     expected_results [$];
  result_t     due;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  int          heading = 0;
  logic signed [7:0] last_cmd = '0;
  logic [2:0]  last_mode = MODE_OFF;

  obstacle_scan_avoid_fsm_top DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .enable          (enable),
    .distance_cm     (distance_cm),
    .yaw_cdeg        (yaw_cdeg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .drive_write     (drive_write),
    .yaw_rate_cmd    (yaw_rate_cmd),
    .mode            (mode),
    .maneuver_active (maneuver_active),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int fold_angle(input int a);
    if (a > 18000) begin
      return a - 36000;
    end else if (a < -18000) begin
      return a + 36000;
    end
    return a;
  endfunction

  function automatic bit timer_hits(input int unsigned lim);
    nav_timer = nav_timer + 16'd1;
    return {16'd0, nav_timer} >= lim;
  endfunction

  function automatic result_t scan_avoid_step(input logic en, input logic [11:0] d,
                                              input logic signed [15:0] y);
    result_t res;
    int   yaw, clr, range, rate, tol, rel, err, v, cmd;
    logic dw;
    yaw   = y;
    clr   = (d == 12'd0) ? FAR_ECHO_CM : int'(d);
    range = int'(tuning.scan_range_cdeg);
    rate  = int'(tuning.turn_rate);
    tol   = int'(tuning.tolerance_cdeg);
    dw    = 1'b0;
    cmd   = 0;
    if (!en) begin
      nav_mode = MODE_OFF;
    end else if (nav_mode == MODE_OFF) begin
      nav_mode  = MODE_IDLE;
      nav_armed = 1'b1;
    end
    if (en) begin
      case (nav_mode)
        MODE_IDLE: begin
          if (d == 12'd0 || d >= tuning.trigger_cm) nav_armed = 1'b1;
          if (nav_armed && d != 12'd0 && d < tuning.trigger_cm) begin
            dw           = 1'b1;
            nav_entry    = yaw;
            nav_best_hdg = 0;
            nav_best_clr = 0;
            nav_armed    = 1'b0;
            nav_timer    = '0;
            nav_mode     = MODE_BRAKE;
          end
        end
        MODE_BRAKE: begin
          dw = 1'b1;
          if (timer_hits(tuning.settle_ticks)) begin
            nav_timer = '0;
            nav_mode  = MODE_SCAN1;
          end
        end
        MODE_SCAN1: begin
          dw  = 1'b1;
          cmd = rate;
          rel = fold_angle(yaw - nav_entry);
          if (clr > nav_best_clr) begin
            nav_best_clr = clr;
            nav_best_hdg = rel;
          end
          if (rel >= range || rel <= -range || timer_hits(tuning.scan_cap)) begin
            nav_sign  = (rel >= 0) ? 1 : -1;
            nav_timer = '0;
            nav_mode  = MODE_SCAN2;
          end
        end
        MODE_SCAN2: begin
          dw  = 1'b1;
          cmd = -rate;
          rel = fold_angle(yaw - nav_entry);
          if (clr > nav_best_clr) begin
            nav_best_clr = clr;
            nav_best_hdg = rel;
          end
          if (nav_sign * rel <= -range || timer_hits(2 * tuning.scan_cap)) begin
            cmd         = 0;
            nav_timer   = '0;
            nav_confirm = '0;
            nav_mode    = MODE_TURN;
          end
        end
        MODE_TURN: begin
          dw  = 1'b1;
          rel = fold_angle(yaw - nav_entry);
          err = fold_angle(nav_best_hdg - rel);
          v   = (nav_sign * err) / 50;
          if (v > rate) v = rate;
          else if (v < -rate) v = -rate;
          cmd = v;
          if (err < tol && err > -tol) nav_confirm = nav_confirm + 8'd1;
          else nav_confirm = '0;
          if (nav_confirm >= tuning.confirm_count || timer_hits(tuning.turn_timeout)) begin
            cmd         = 0;
            nav_timer   = '0;
            nav_confirm = '0;
            nav_mode    = MODE_DONE;
          end
        end
        MODE_DONE: begin
          dw = 1'b1;
          if (timer_hits(tuning.settle_ticks)) begin
            nav_timer = '0;
            nav_mode  = MODE_IDLE;
          end
        end
        default: begin
          nav_mode = MODE_IDLE;
        end
      endcase
    end
    res.drive_write     = dw;
    res.yaw_rate_cmd    = cmd[7:0];
    res.mode            = nav_mode;
    res.maneuver_active = (nav_mode > MODE_IDLE);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
  endtask

  // block must be idle here
  task automatic load_tuning(input cfg_t c);
    write_reg(REG_TRIGGER_CM, CFG_DATA_W'(c.trigger_cm));
    write_reg(REG_TURN_RATE, CFG_DATA_W'(c.turn_rate));
    write_reg(REG_SCAN_RANGE, CFG_DATA_W'(c.scan_range_cdeg));
    write_reg(REG_SCAN_CAP, CFG_DATA_W'(c.scan_cap));
    write_reg(REG_SETTLE_TICKS, c.settle_ticks);
    write_reg(REG_TURN_TIMEOUT, c.turn_timeout);
    write_reg(REG_TOLERANCE, CFG_DATA_W'(c.tolerance_cdeg));
    write_reg(REG_CONFIRM, CFG_DATA_W'(c.confirm_count));
    wr_en  <= 1'b0;
    tuning  = c;
    @(posedge clk);
  endtask

  task automatic send_request(input logic en, input logic [11:0] d,
                              input logic signed [15:0] y, input bit pinned,
                              input result_t want);
    result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    enable      <= en;
    distance_cm <= d;
    yaw_cdeg    <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = scan_avoid_step(en, d, y);
    expected_results.push_back(pinned ? want : r);
    last_cmd  = r.yaw_rate_cmd;
    last_mode = r.mode;
  endtask

  // heading follows the commanded yaw rate, so sweeps and turns run to completion
  task automatic send_random_request();
    logic        en;
    logic [11:0] d;
    int          trig, pick;
    trig = int'(tuning.trigger_cm);
    if ($urandom_range(0, 99) < 8) begin
      en      = ($urandom_range(0, 9) != 0);
      d       = 12'($urandom_range(0, 4095));
      heading = int'($urandom_range(0, 36000)) - 18000;
    end else begin
      en      = ($urandom_range(0, 99) != 0);
      heading = heading + 20 * int'(last_cmd) + int'($urandom_range(0, 60)) - 30;
      if (heading > 18000) heading -= 36000;
      else if (heading < -18000) heading += 36000;
      if (last_mode == MODE_IDLE || last_mode == MODE_OFF) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) d = (trig > 1) ? 12'($urandom_range(1, trig - 1)) : 12'd1;
        else if (pick < 28) d = 12'd0;
        else d = 12'($urandom_range(trig, 4095));
      end else begin
        d = ($urandom_range(0, 6) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
      end
    end
    send_request(en, d, 16'(heading), 1'b0, R_NONE);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, mode", int'(mode), 0);
        end else begin
          due = expected_results.pop_front();
          if (drive_write !== due.drive_write)
            report_mismatch("drive_write", int'(drive_write), int'(due.drive_write));
          if (yaw_rate_cmd !== $signed(due.yaw_rate_cmd))
            report_mismatch("yaw_rate_cmd", int'(yaw_rate_cmd), int'($signed(due.yaw_rate_cmd)));
          if (mode !== due.mode)
            report_mismatch("mode", int'(mode), int'(due.mode));
          if (maneuver_active !== due.maneuver_active)
            report_mismatch("maneuver_active", int'(maneuver_active),
                            int'(due.maneuver_active));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t drawn;
    tuning = phase_tunings[0];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    load_tuning(DIRECTED_TUNING);
    foreach (probes[i])
      send_request(probes[i].en, probes[i].dist_cm, 16'(probes[i].yaw), probes[i].pinned,
                   probes[i].want);
    drain_results();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        drawn.trigger_cm      = 12'($urandom_range(1, 4095));
        drawn.turn_rate       = 7'($urandom_range(0, 127));
        drawn.scan_range_cdeg = 15'($urandom_range(1, 18000));
        drawn.scan_cap        = 15'($urandom_range(1, 60));
        drawn.settle_ticks    = 16'($urandom_range(1, 20));
        drawn.turn_timeout    = 16'($urandom_range(1, 200));
        drawn.tolerance_cdeg  = 15'($urandom_range(0, 18000));
        drawn.confirm_count   = 8'($urandom_range(1, 20));
        phase_tunings[p]      = drawn;
      end
      load_tuning(phase_tunings[p]);
      for (int k = 0; k < phase_items[p]; k++) begin
        calm = (p == 5) && (k >= 30) && (k < 230);
        send_random_request();
      end
      calm = 1'b0;
      drain_results();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
